FILE: rtl/core/pcm_pkg.sv
// Package for the palette colour matcher: widths, transaction structs, codes and state types.
// Depends on nothing; every module of the block imports it.
package pcm_pkg;

    localparam int PALETTE_DEPTH = 1024;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int THR_W         = 20;
    localparam int STEP_W        = 16;
    localparam int SKIP_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 20;
    localparam int DIST_W        = 30;
    localparam int SUM_W         = ((IDX_W > SKIP_W) ? IDX_W : SKIP_W) + 1;

    localparam logic [THR_W-1:0]     THR_MAX         = '1;
    localparam logic [THR_W-1:0]     EPS_START_RESET = THR_W'(500);
    localparam logic [STEP_W-1:0]    EPS_STEP_RESET  = STEP_W'(300);
    localparam logic [SKIP_W-1:0]    SKIP_RESET      = SKIP_W'(300);

    localparam logic [CFG_IDX_W-1:0] CFG_EPS_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP      = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_MATCH  = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        logic       op;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } item_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] match_index;
        logic [THR_W-1:0] final_threshold;
    } result_t;

    // One palette entry as stored: red in the top byte, blue in the bottom byte.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIST_START,
        S_DIST_WAIT,
        S_MOD_WAIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        DS_IDLE,
        DS_RSQ,
        DS_RW,
        DS_GSQ,
        DS_GW,
        DS_BSQ,
        DS_BW
    } dist_step_t;

endpackage

FILE: rtl/core/pcm_dist_unit.sv
// Iterative redmean distance unit: one shared 11x16 multiplier stepped by a small sequencer.
// Depends on pcm_pkg.
module pcm_dist_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  pcm_pkg::entry_t             pixel,
    input  pcm_pkg::entry_t             entry,
    output logic                        done,
    output logic [pcm_pkg::DIST_W-1:0]  distance
);
    import pcm_pkg::*;

    localparam logic [10:0] W_RED_BASE  = 11'd1024;
    localparam logic [10:0] W_BLUE_BASE = 11'd1534;

    dist_step_t        state_reg, state_next;
    logic [8:0]        sr_reg;
    logic [7:0]        dr_reg, dg_reg, db_reg;
    logic [15:0]       sq_reg;
    logic [DIST_W-1:0] acc_reg;
    logic              done_reg;
    logic [10:0]       mul_a;
    logic [15:0]       mul_b;
    logic [26:0]       prod;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == DS_BW);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DS_IDLE: if (start) state_next = DS_RSQ;
            DS_RSQ:  state_next = DS_RW;
            DS_RW:   state_next = DS_GSQ;
            DS_GSQ:  state_next = DS_GW;
            DS_GW:   state_next = DS_BSQ;
            DS_BSQ:  state_next = DS_BW;
            DS_BW:   state_next = DS_IDLE;
            default: state_next = DS_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            DS_RSQ:
            begin
                mul_a = {3'b0, dr_reg};
                mul_b = {8'b0, dr_reg};
            end
            DS_RW:
            begin
                mul_a = W_RED_BASE + {2'b0, sr_reg};
                mul_b = sq_reg;
            end
            DS_GSQ:
            begin
                mul_a = {3'b0, dg_reg};
                mul_b = {8'b0, dg_reg};
            end
            DS_BSQ:
            begin
                mul_a = {3'b0, db_reg};
                mul_b = {8'b0, db_reg};
            end
            DS_BW:
            begin
                mul_a = W_BLUE_BASE - {2'b0, sr_reg};
                mul_b = sq_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = {16'b0, mul_a} * {11'b0, mul_b};

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DS_IDLE:
            begin
                if (start)
                begin
                    sr_reg <= {1'b0, pixel.red} + {1'b0, entry.red};
                    dr_reg <= abs_diff(pixel.red, entry.red);
                    dg_reg <= abs_diff(pixel.green, entry.green);
                    db_reg <= abs_diff(pixel.blue, entry.blue);
                end
            end
            DS_RSQ:
            begin
                sq_reg  <= prod[15:0];
                acc_reg <= '0;
            end
            DS_RW:  acc_reg <= acc_reg + DIST_W'(prod);
            DS_GSQ: sq_reg  <= prod[15:0];
            DS_GW:  acc_reg <= acc_reg + DIST_W'({sq_reg, 11'b0});
            DS_BSQ: sq_reg  <= prod[15:0];
            DS_BW:  acc_reg <= acc_reg + DIST_W'(prod);
            default: acc_reg <= acc_reg;
        endcase
    end

    assign done     = done_reg;
    assign distance = acc_reg;

endmodule

FILE: rtl/core/pcm_mod_unit.sv
// Restoring modulo unit: reduces the advanced pointer by the entry count, one bit per cycle.
// Depends on pcm_pkg.
module pcm_mod_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pcm_pkg::SUM_W-1:0]   value,
    input  logic [pcm_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [pcm_pkg::IDX_W-1:0]   rem
);
    import pcm_pkg::*;

    localparam int DIVSH_W = CNT_W + SUM_W - 1;
    localparam int BIT_W   = $clog2(SUM_W);

    logic               busy_reg;
    logic               done_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [DIVSH_W-1:0] div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && (bit_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= value;
            div_reg <= DIVSH_W'(divisor) << (SUM_W - 1);
            bit_reg <= BIT_W'(SUM_W - 1);
        end
        else if (busy_reg)
        begin
            // The remainder is reduced when the shifted divisor fits into it.
            if (DIVSH_W'(rem_reg) >= div_reg)
                rem_reg <= rem_reg - div_reg[SUM_W-1:0];
            div_reg <= div_reg >> 1;
            bit_reg <= bit_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[IDX_W-1:0];

endmodule

FILE: rtl/core/palette_color_match_search_top.sv
// Top level of the palette colour matcher: palette memory, configuration and search sequencer.
// Depends on pcm_pkg, pcm_dist_unit and pcm_mod_unit.
//
// A transaction is taken when start is high and busy is low. A load transaction appends
// one colour to the palette and its result appears on the next cycle, so loads may follow
// one another every cycle. A query transaction keeps busy high while it walks the palette
// circularly from the kept search pointer: each visited entry takes one memory read, one
// operand latch, six steps of the sequencer in the distance unit and one compare, and
// the pointer update after a match runs the bit-serial modulo by the entry count
// (seventeen restoring steps, after which the remainder is handed back). A query that
// finds its match shows its result in the same cycle in which busy falls; a query on an
// empty palette answers on the next cycle. Every result is shown for exactly one cycle
// with done high and must be taken then, as the receiver cannot stall the block. The
// palette memory needs no clearing pass after reset, since only entries below the fill
// count are read.
module palette_color_match_search_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  pcm_pkg::item_t                  item,
    output logic                            done,
    output pcm_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [pcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pcm_pkg::*;

    // Control state and search context.
    ctrl_state_t       state_reg, state_next;
    item_t             item_reg, item_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  visit_reg, visit_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic              done_reg, done_next;
    result_t           res_reg, res_next;

    // Configuration registers.
    logic [THR_W-1:0]  eps_start_reg;
    logic [STEP_W-1:0] eps_step_reg;
    logic [SKIP_W-1:0] skip_reg;

    // Palette memory.
    entry_t            mem [PALETTE_DEPTH];
    entry_t            mem_q;
    entry_t            mem_wdata;
    logic              mem_we;

    // Shared units.
    entry_t            pixel;
    logic              dist_start, dist_done;
    logic [DIST_W-1:0] distance;
    logic              mod_start, mod_done;
    logic [SUM_W-1:0]  mod_value;
    logic [IDX_W-1:0]  mod_rem;

    logic              hit;
    logic [THR_W:0]    thr_sum;
    logic [THR_W-1:0]  thr_grown;

    assign pixel     = '{red: item_reg.red, green: item_reg.green, blue: item_reg.blue};
    assign mem_wdata = '{red: item.red, green: item.green, blue: item.blue};
    assign mod_value = SUM_W'(idx_reg) + SUM_W'(skip_reg);

    // The scaled distance is compared with the threshold times 512.
    assign hit = ({1'b0, distance} <= (DIST_W + 1)'({thr_reg, 9'b0}));

    // A zero step jumps straight to the maximum; otherwise the threshold saturates.
    assign thr_sum   = {1'b0, thr_reg} + (THR_W + 1)'(eps_step_reg);
    assign thr_grown = ((eps_step_reg == '0) || thr_sum[THR_W]) ? THR_MAX : thr_sum[THR_W-1:0];

    pcm_dist_unit u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dist_start),
        .pixel    (pixel),
        .entry    (mem_q),
        .done     (dist_done),
        .distance (distance)
    );

    pcm_mod_unit u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .value   (mod_value),
        .divisor (count_reg),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    // The palette is written only at the fill count and only while that is below the depth,
    // so the write address never reaches the depth.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[IDX_W-1:0]] <= mem_wdata;
        mem_q <= mem[idx_reg];
    end

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_start_reg <= EPS_START_RESET;
            eps_step_reg  <= EPS_STEP_RESET;
            skip_reg      <= SKIP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EPS_START: eps_start_reg <= cfg_data[THR_W-1:0];
                CFG_EPS_STEP:  eps_step_reg  <= cfg_data[STEP_W-1:0];
                CFG_SKIP:      skip_reg      <= cfg_data[SKIP_W-1:0];
                default:       eps_start_reg <= eps_start_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        idx_reg   <= idx_next;
        visit_reg <= visit_next;
        thr_reg   <= thr_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        idx_next   = idx_reg;
        visit_next = visit_reg;
        thr_next   = thr_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        mem_we     = 1'b0;
        dist_start = 1'b0;
        mod_start  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    if (item.op == OP_LOAD)
                    begin
                        done_next = 1'b1;
                        if (count_reg >= CNT_W'(PALETTE_DEPTH))
                        begin
                            res_next = '{status: ST_FULL, match_index: '0, final_threshold: '0};
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            res_next   = '{status: ST_STORED, match_index: '0,
                                           final_threshold: '0};
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next = 1'b1;
                        res_next  = '{status: ST_EMPTY, match_index: '0, final_threshold: '0};
                    end
                    else
                    begin
                        // A pointer left beyond the fill count restarts the walk at entry zero.
                        idx_next   = (CNT_W'(ptr_reg) >= count_reg) ? '0 : ptr_reg;
                        visit_next = '0;
                        thr_next   = eps_start_reg;
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_DIST_START;
            end

            S_DIST_START:
            begin
                dist_start = 1'b1;
                state_next = S_DIST_WAIT;
            end

            S_DIST_WAIT:
            begin
                if (dist_done)
                begin
                    if (hit)
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MOD_WAIT;
                    end
                    else
                    begin
                        // Step circularly; after a whole unmatched pass widen the threshold.
                        if ((CNT_W'(idx_reg) + 1'b1) == count_reg)
                            idx_next = '0;
                        else
                            idx_next = idx_reg + 1'b1;
                        if ((CNT_W'(visit_reg) + 1'b1) == count_reg)
                        begin
                            visit_next = '0;
                            thr_next   = thr_grown;
                        end
                        else
                        begin
                            visit_next = visit_reg + 1'b1;
                        end
                        state_next = S_READ;
                    end
                end
            end

            S_MOD_WAIT:
            begin
                if (mod_done)
                begin
                    ptr_next   = mod_rem;
                    done_next  = 1'b1;
                    res_next   = '{status: ST_MATCH, match_index: idx_reg,
                                   final_threshold: thr_reg};
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: rtl/core/pcm_checker.sv
// Port-level checker for the palette colour matcher, bound to the top level.
// Depends on pcm_pkg and palette_color_match_search_top.
module pcm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input pcm_pkg::item_t   item,
    input logic             done,
    input pcm_pkg::result_t result
);
    import pcm_pkg::*;

    // A load transaction answers on the very next cycle with stored or full.
    a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.op == OP_LOAD)) |=>
            (done && ((result.status == ST_STORED) || (result.status == ST_FULL))))
        else $error("load transaction without a stored or full result");

    // A query either starts a search or reports an empty palette at once.
    a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.op == OP_QUERY)) |=>
            (busy || (done && (result.status == ST_EMPTY))))
        else $error("query transaction neither searching nor reporting empty");

    // A result never coincides with a search still in progress.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // The end of a search always delivers its result.
    a_search_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (done && (result.status == ST_MATCH)))
        else $error("search ended without a match result");

    // Index and threshold are zero unless a match is reported.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_MATCH)) |->
            ((result.match_index == '0) && (result.final_threshold == '0)))
        else $error("non-match result with non-zero fields");

endmodule

bind palette_color_match_search_top pcm_checker u_pcm_checker (.*);
